@@ rtl/bnfa_pkg.sv @@
package bnfa_pkg;

    // Program store geometry
    localparam int PROG_DEPTH  = 64;
    localparam int SLOT_W      = $clog2(PROG_DEPTH);
    localparam int TGT_W       = SLOT_W + 1;      // target incl. one-past-end
    localparam int LEN_W       = 7;
    localparam int CNT_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int OP_W        = 3;
    localparam int REL_W       = 7;               // signed next/alt slot fields
    localparam int MODE_W      = 2;

    // Status scan: active set is counted one chunk per cycle
    localparam int CHUNK_W     = 8;
    localparam int N_CHUNK     = PROG_DEPTH / CHUNK_W;
    localparam int CHUNK_IDX_W = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;

    // Stream payload layout
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;
    localparam int F_SLOT_LSB  = 0;
    localparam int F_OP_LSB    = F_SLOT_LSB + SLOT_W;
    localparam int F_LO_LSB    = F_OP_LSB + OP_W;
    localparam int F_HI_LSB    = F_LO_LSB + BYTE_W;
    localparam int F_NXT_LSB   = F_HI_LSB + BYTE_W;
    localparam int F_ALT_LSB   = F_NXT_LSB + REL_W;
    localparam int F_TXT_LSB   = F_ALT_LSB + REL_W;

    // Item modes
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_LOAD  = 2'd0;
    localparam t_mode MODE_START = 2'd1;
    localparam t_mode MODE_STEP  = 2'd2;

    // Opcodes
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_CHAR  = 3'd0;
    localparam t_op OP_RANGE = 3'd1;
    localparam t_op OP_ANY   = 3'd2;
    localparam t_op OP_NOT   = 3'd3;
    localparam t_op OP_SPLIT = 3'd4;
    localparam t_op OP_JMP   = 3'd5;
    localparam t_op OP_MATCH = 3'd6;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic seed;
        logic hop;
        logic commit;
        logic count_clr;
        logic count_step;
        logic out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic frontier_empty;
        logic count_last;
    } t_status;

endpackage

@@ rtl/byte_nfa_active_set_stepper.sv @@
// Byte NFA active-set stepper.
// Input stream (s_axis): one transaction per item. tuser carries the mode
// (load slot, start at slot 0, step one text byte); tdata carries the slot
// fields and the text byte. Output stream (m_axis): one status transaction
// per input item, in order: alive, can_stop and the active slot count.
// The program length register is written through i_cfg_wr_en/i_cfg_wr_data;
// the user must write it only while no item is in progress, as the block
// itself does not enforce this. Load and ignored-mode items go from accept
// to the status scan over 8-slot chunks and then the output load; start and
// step items add a seed step and closure hops before the scan, following
// SPLIT/JMP chains one hop per cycle over the whole bit set until a cycle
// sees the frontier empty; with an empty seed the first closure check already
// sees it empty. One item is handled at a time; the next is accepted the
// cycle after the result is placed in the output register.
// Reset clears the active set and the length register; program slots keep
// whatever they held and must be loaded before use.
// If the receiver stalls, the result waits in the output register, the next
// item still runs, and it holds in its last cycle until the register frees.
module byte_nfa_active_set_stepper (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // slot[5:0], op_code[8:6], lo_byte[16:9], hi_byte[24:17],
    // next_slot[31:25], alt_slot[38:32], text_byte[46:39], zero[47]
    input  logic [bnfa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // mode[1:0]
    input  logic [bnfa_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // alive[0], can_stop[1], active_count[8:2], zero[15:9]
    output logic [bnfa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [bnfa_pkg::LEN_W-1:0]        i_cfg_wr_data
);
    import bnfa_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    bnfa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_mode    (s_axis_tuser),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    // Program store, active set, closure and status scan
    bnfa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .o_m_tdata     (m_axis_tdata)
    );

endmodule

@@ rtl/bnfa_ctrl.sv @@
module bnfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  bnfa_pkg::t_mode   i_mode,
    input  logic              i_m_ready,
    input  bnfa_pkg::t_status i_status,
    output logic              o_s_ready,
    output logic              o_m_valid,
    output bnfa_pkg::t_cmd    o_cmd
);
    import bnfa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_HOP,
        ST_COUNT,
        ST_PUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    t_cmd   w_cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.accept = 1'b1;
                    if (i_mode inside {MODE_START, MODE_STEP}) begin
                        n_state = ST_SEED;
                    end else begin
                        w_cmd.count_clr = 1'b1;
                        n_state         = ST_COUNT;
                    end
                end
            end
            ST_SEED: begin
                w_cmd.seed = 1'b1;
                n_state    = ST_HOP;
            end
            ST_HOP: begin
                if (i_status.frontier_empty) begin
                    w_cmd.commit    = 1'b1;
                    w_cmd.count_clr = 1'b1;
                    n_state         = ST_COUNT;
                end else begin
                    w_cmd.hop = 1'b1;
                end
            end
            ST_COUNT: begin
                w_cmd.count_step = 1'b1;
                if (i_status.count_last) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_m_valid || i_m_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Output slot: held until taken, refilled from the datapath
        n_m_valid = r_m_valid && !i_m_ready;
        if (w_cmd.out_load) begin
            n_m_valid = 1'b1;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;
    assign o_cmd     = w_cmd;

    // One item in flight: the cycle after an accept the input side is closed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> !o_s_ready)
        else $error("input accepted while previous item in progress");

    // A result is only produced after the status scan
    a_push_after_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> ($past(r_state) == ST_COUNT || $past(r_state) == ST_PUSH))
        else $error("result loaded without status scan");

endmodule

@@ rtl/bnfa_dp.sv @@
module bnfa_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bnfa_pkg::t_cmd                   i_cmd,
    output bnfa_pkg::t_status                o_status,
    input  logic                             i_cfg_wr_en,
    input  logic [bnfa_pkg::LEN_W-1:0]       i_cfg_wr_data,
    input  logic [bnfa_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  bnfa_pkg::t_mode                  i_s_tuser,
    output logic [bnfa_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import bnfa_pkg::*;

    // Program store, one register set per slot
    t_op               r_op  [PROG_DEPTH];
    logic [BYTE_W-1:0] r_lo  [PROG_DEPTH];
    logic [BYTE_W-1:0] r_hi  [PROG_DEPTH];
    logic [REL_W-1:0]  r_nxt [PROG_DEPTH];
    logic [REL_W-1:0]  r_alt [PROG_DEPTH];

    logic [LEN_W-1:0]       r_len;
    t_mode                  r_mode;
    logic [BYTE_W-1:0]      r_byte;
    logic [PROG_DEPTH-1:0]  r_active;
    logic [PROG_DEPTH-1:0]  r_visited;
    logic [PROG_DEPTH-1:0]  r_frontier;
    logic [PROG_DEPTH-1:0]  r_keep;
    logic [CHUNK_IDX_W-1:0] r_cidx;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_stop;
    logic [M_TDATA_W-1:0]   r_out;

    // Per-slot decode
    logic [PROG_DEPTH-1:0] w_cons, w_match, w_split, w_jmp, w_acc, w_alt_ok;
    logic [TGT_W-1:0]      w_tgt_n [PROG_DEPTH];
    logic [TGT_W-1:0]      w_tgt_a [PROG_DEPTH];
    logic [PROG_DEPTH-1:0] w_fire_n, w_fire_a, w_succ, w_lenmask;
    logic [PROG_DEPTH-1:0] w_seedv, w_newv;
    logic [CHUNK_W-1:0]    w_chunk, w_mchunk;
    logic [SLOT_W-1:0]     w_wslot;

    function automatic logic [CNT_W-1:0] popcnt(input logic [CHUNK_W-1:0] v);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int k = 0; k < CHUNK_W; k++) begin
            s = s + CNT_W'(v[k]);
        end
        return s;
    endfunction

    assign w_wslot = i_s_tdata[F_SLOT_LSB +: SLOT_W];

    // Decode each slot: class, byte test and targets
    always_comb begin
        for (int i = 0; i < PROG_DEPTH; i++) begin
            w_cons[i]   = (r_op[i] <= OP_NOT);
            w_match[i]  = (r_op[i] == OP_MATCH);
            w_split[i]  = (r_op[i] == OP_SPLIT);
            w_jmp[i]    = (r_op[i] == OP_JMP);
            case (r_op[i])
                OP_CHAR:  w_acc[i] = (r_byte == r_lo[i]);
                OP_RANGE: w_acc[i] = (r_byte >= r_lo[i]) && (r_byte <= r_hi[i]);
                OP_ANY:   w_acc[i] = (r_byte != '0);
                OP_NOT:   w_acc[i] = (r_byte != r_lo[i]);
                default:  w_acc[i] = 1'b0;
            endcase
            // negative next falls through to the following slot
            w_tgt_n[i]  = r_nxt[i][REL_W-1] ? TGT_W'(i + 1) : TGT_W'(r_nxt[i]);
            w_tgt_a[i]  = TGT_W'(r_alt[i]);
            w_alt_ok[i] = !r_alt[i][REL_W-1];
        end
    end

    // Which slots fire: byte-accepting consumers at seed, SPLIT/JMP during hops
    always_comb begin
        if (i_cmd.seed) begin
            w_fire_n = r_active & w_cons & w_acc;
            w_fire_a = '0;
        end else begin
            w_fire_n = r_frontier & (w_split | w_jmp);
            w_fire_a = r_frontier & w_split & w_alt_ok;
        end
    end

    // Scatter fired slots onto their targets, drop targets past the length
    always_comb begin
        for (int t = 0; t < PROG_DEPTH; t++) begin
            w_succ[t] = 1'b0;
            for (int i = 0; i < PROG_DEPTH; i++) begin
                w_succ[t] = w_succ[t]
                          | (w_fire_n[i] & (w_tgt_n[i] == TGT_W'(t)))
                          | (w_fire_a[i] & (w_tgt_a[i] == TGT_W'(t)));
            end
            w_lenmask[t] = (TGT_W'(t) < TGT_W'(r_len));
        end
    end

    assign w_seedv = ((r_mode == MODE_START) ? PROG_DEPTH'(1) : w_succ) & w_lenmask;
    assign w_newv  = w_succ & w_lenmask & ~r_visited;

    assign w_chunk  = r_active[r_cidx*CHUNK_W +: CHUNK_W];
    assign w_mchunk = w_match[r_cidx*CHUNK_W +: CHUNK_W];

    // Program store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_s_tuser == MODE_LOAD) begin
            r_op[w_wslot]  <= i_s_tdata[F_OP_LSB  +: OP_W];
            r_lo[w_wslot]  <= i_s_tdata[F_LO_LSB  +: BYTE_W];
            r_hi[w_wslot]  <= i_s_tdata[F_HI_LSB  +: BYTE_W];
            r_nxt[w_wslot] <= i_s_tdata[F_NXT_LSB +: REL_W];
            r_alt[w_wslot] <= i_s_tdata[F_ALT_LSB +: REL_W];
        end
    end

    // Item latch, status scan and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_s_tuser;
            r_byte <= i_s_tdata[F_TXT_LSB +: BYTE_W];
        end
        if (i_cmd.count_clr) begin
            r_cidx <= '0;
            r_cnt  <= '0;
            r_stop <= 1'b0;
        end else if (i_cmd.count_step) begin
            r_cidx <= r_cidx + 1'b1;
            r_cnt  <= r_cnt + popcnt(w_chunk);
            r_stop <= r_stop | (|(w_chunk & w_mchunk));
        end
        if (i_cmd.out_load) begin
            r_out <= M_TDATA_W'({r_cnt, r_stop, (r_cnt != '0)});
        end
    end

    // Length register and closure state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_active   <= '0;
            r_visited  <= '0;
            r_frontier <= '0;
            r_keep     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (i_cmd.seed) begin
                r_visited  <= w_seedv;
                r_frontier <= w_seedv;
                // MATCH slots already active are absorbing
                r_keep     <= (r_mode == MODE_STEP) ? (r_active & w_match) : '0;
            end else if (i_cmd.hop) begin
                r_visited  <= r_visited | w_newv;
                r_frontier <= w_newv;
            end
            if (i_cmd.commit) begin
                r_active <= r_keep | (r_visited & (w_cons | w_match));
            end
        end
    end

    assign o_status.frontier_empty = (r_frontier == '0);
    assign o_status.count_last     = (r_cidx == CHUNK_IDX_W'(N_CHUNK - 1));
    assign o_m_tdata               = r_out;

    a_front_in_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frontier & ~r_visited) == '0)
        else $error("frontier slot not marked visited");

    a_hop_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hop |=> ((r_frontier & $past(r_visited)) == '0))
        else $error("closure hop revisited a slot");

endmodule

@@ bench/tb_byte_nfa_active_set_stepper.sv @@
`timescale 1ns / 1ps

module tb_byte_nfa_active_set_stepper;
    import bnfa_pkg::*;

    localparam t_mode MODE_IGNORED = 2'd3;   // undefined mode, block leaves state alone
    localparam t_op   OP_DEAD      = 3'd7;   // undefined opcode, dead end
    localparam int    RANDOM_ITEMS = 1250;
    localparam int    SETTLE       = 4;
    localparam int    DRAIN_CYCLES = 100;

    typedef struct {
        t_mode                   mode;
        logic [SLOT_W-1:0]       slot;
        t_op                     op;
        logic [BYTE_W-1:0]       lo;
        logic [BYTE_W-1:0]       hi;
        logic signed [REL_W-1:0] nxt;
        logic signed [REL_W-1:0] alt;
        logic [BYTE_W-1:0]       text;
    } t_nfa_item;

    typedef struct {
        logic             alive;
        logic             can_stop;
        logic [CNT_W-1:0] count;
    } t_nfa_status;

    typedef enum {RX_OPEN, RX_COIN, RX_CHOKED, RX_PERIODIC} t_rx_pattern;

    // Predicts the status word of every item and checks the results in order
    class nfa_scoreboard;
        t_op                     op_mem  [PROG_DEPTH];
        logic [BYTE_W-1:0]       lo_mem  [PROG_DEPTH];
        logic [BYTE_W-1:0]       hi_mem  [PROG_DEPTH];
        logic signed [REL_W-1:0] nxt_mem [PROG_DEPTH];
        logic signed [REL_W-1:0] alt_mem [PROG_DEPTH];
        bit [PROG_DEPTH-1:0]     live_set;
        bit [PROG_DEPTH-1:0]     loaded;
        int                      length_reg;
        t_nfa_status             status_q[$];
        int                      errors;

        function new();
            live_set   = '0;
            loaded     = '0;
            length_reg = 0;
            errors     = 0;
        endfunction

        function void set_length(int value);
            length_reg = value;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // Targets are checked against the length in force right now
        function bit in_program(int t);
            return t >= 0 && t < ((length_reg < PROG_DEPTH) ? length_reg : PROG_DEPTH);
        endfunction

        function int successor(int s);
            return (nxt_mem[s] < 0) ? s + 1 : int'(nxt_mem[s]);
        endfunction

        function bit takes_byte(int s, logic [BYTE_W-1:0] c);
            case (op_mem[s])
                OP_CHAR:  return c == lo_mem[s];
                OP_RANGE: return c >= lo_mem[s] && c <= hi_mem[s];
                OP_ANY:   return c != 8'h00;
                OP_NOT:   return c != lo_mem[s];
                default:  return 1'b0;
            endcase
        endfunction

        // Follow SPLIT/JMP from the seeds, keep consumers and MATCH slots
        function bit [PROG_DEPTH-1:0] eps_closure(bit [PROG_DEPTH-1:0] seeds);
            bit [PROG_DEPTH-1:0] reached;
            bit [PROG_DEPTH-1:0] frontier;
            bit [PROG_DEPTH-1:0] fresh;
            bit [PROG_DEPTH-1:0] kept;
            int                  t;
            reached  = seeds;
            frontier = seeds;
            kept     = '0;
            while (frontier != '0) begin
                fresh = '0;
                for (int i = 0; i < PROG_DEPTH; i++) begin
                    if (frontier[i] && (op_mem[i] == OP_SPLIT || op_mem[i] == OP_JMP)) begin
                        t = successor(i);
                        if (in_program(t) && !reached[t]) fresh[t] = 1'b1;
                        t = int'(alt_mem[i]);
                        if (op_mem[i] == OP_SPLIT && in_program(t) && !reached[t])
                            fresh[t] = 1'b1;
                    end
                end
                reached  = reached | fresh;
                frontier = fresh;
            end
            for (int i = 0; i < PROG_DEPTH; i++) begin
                if (reached[i] && (op_mem[i] <= OP_NOT || op_mem[i] == OP_MATCH)) kept[i] = 1'b1;
            end
            return kept;
        endfunction

        function void note_item(t_nfa_item it);
            bit [PROG_DEPTH-1:0] seeds;
            bit [PROG_DEPTH-1:0] held;
            t_nfa_status         st;
            int                  t;
            seeds = '0;
            held  = '0;
            case (it.mode)
                MODE_LOAD: begin
                    op_mem[it.slot]  = it.op;
                    lo_mem[it.slot]  = it.lo;
                    hi_mem[it.slot]  = it.hi;
                    nxt_mem[it.slot] = it.nxt;
                    alt_mem[it.slot] = it.alt;
                    loaded[it.slot]  = 1'b1;
                end
                MODE_START: begin
                    if (in_program(0)) seeds[0] = 1'b1;
                    live_set = eps_closure(seeds);
                end
                MODE_STEP: begin
                    // MATCH is absorbing; accepting consumers move on
                    for (int i = 0; i < PROG_DEPTH; i++) begin
                        if (live_set[i]) begin
                            if (op_mem[i] == OP_MATCH) begin
                                held[i] = 1'b1;
                            end else if (takes_byte(i, it.text)) begin
                                t = successor(i);
                                if (in_program(t)) seeds[t] = 1'b1;
                            end
                        end
                    end
                    live_set = held | eps_closure(seeds);
                end
                default: ;
            endcase
            // status reads the opcodes stored now
            st.count    = '0;
            st.can_stop = 1'b0;
            for (int i = 0; i < PROG_DEPTH; i++) begin
                if (live_set[i]) begin
                    st.count = st.count + 1'b1;
                    if (op_mem[i] == OP_MATCH) st.can_stop = 1'b1;
                end
            end
            st.alive = (st.count != '0);
            status_q.push_back(st);
        endfunction

        function void compare_field(string name, int expected, int actual);
            if (expected != actual) begin
                $display("%0t: %s mismatch, expected %0d actual %0d",
                         $time, name, expected, actual);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            t_nfa_status exp_st;
            if (status_q.size() == 0) begin
                $display("%0t: status with no item waiting, expected none actual %h",
                         $time, word);
                errors++;
                return;
            end
            exp_st = status_q.pop_front();
            compare_field("alive", exp_st.alive, word[0]);
            compare_field("can_stop", exp_st.can_stop, word[1]);
            compare_field("active_count", exp_st.count, word[2 +: CNT_W]);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // slot, op_code, lo_byte, hi_byte, next_slot, alt_slot, text_byte, zero
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    // mode
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // alive, can_stop, active_count, zero
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wr_data = '0;

    nfa_scoreboard sb;
    int            burst_left = 0;
    bit            steady     = 1'b0;
    t_rx_pattern   rx_pattern = RX_OPEN;
    int            rx_left    = 0;
    int unsigned   rx_tick    = 0;

    byte_nfa_active_set_stepper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: switches between stall patterns every so often
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_pattern <= t_rx_pattern'($urandom_range(0, 3));
            rx_left    <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_pattern)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_CHOKED: m_axis_tready <= ($urandom_range(0, 9) == 0);
            default:   m_axis_tready <= (rx_tick[2:0] == 3'd0);
        endcase
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    function automatic t_nfa_item make_item(t_mode mode, int slot, t_op op, int lo, int hi,
                                            int nxt, int alt, int text);
        t_nfa_item it;
        it.mode = mode;
        it.slot = slot[SLOT_W-1:0];
        it.op   = op;
        it.lo   = lo[BYTE_W-1:0];
        it.hi   = hi[BYTE_W-1:0];
        it.nxt  = nxt[REL_W-1:0];
        it.alt  = alt[REL_W-1:0];
        it.text = text[BYTE_W-1:0];
        return it;
    endfunction

    // Small alphabet so that text bytes hit the program now and then
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return BYTE_W'($urandom_range(0, 255));
            default: return 8'h61 + BYTE_W'($urandom_range(0, 2));
        endcase
    endfunction

    // Mostly inside the program, sometimes fall-through or beyond the end
    function automatic int pick_target(int span);
        case ($urandom_range(0, 9))
            0, 1:    return -int'($urandom_range(1, 64));
            2:       return $urandom_range(0, 63);
            default: return $urandom_range(0, span - 1);
        endcase
    endfunction

    function automatic t_nfa_item random_item(t_mode mode, int slot, int span);
        int  roll;
        t_op op;
        roll = $urandom_range(0, 99);
        if (roll < 55)      op = t_op'($urandom_range(0, 3));
        else if (roll < 72) op = OP_SPLIT;
        else if (roll < 82) op = OP_JMP;
        else if (roll < 97) op = OP_MATCH;
        else                op = OP_DEAD;
        return make_item(mode, slot, op, pick_byte(), pick_byte(), pick_target(span),
                         pick_target(span), pick_byte());
    endfunction

    // One input transaction; the sender runs in bursts unless the phase is steady
    task automatic send_item(t_nfa_item it);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[F_SLOT_LSB +: SLOT_W] = it.slot;
        word[F_OP_LSB   +: OP_W]   = it.op;
        word[F_LO_LSB   +: BYTE_W] = it.lo;
        word[F_HI_LSB   +: BYTE_W] = it.hi;
        word[F_NXT_LSB  +: REL_W]  = it.nxt;
        word[F_ALT_LSB  +: REL_W]  = it.alt;
        word[F_TXT_LSB  +: BYTE_W] = it.text;
        if (!steady && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        if (burst_left > 0) burst_left--;
    endtask

    // Hold the sender until every status has come back
    task automatic wait_drained(int settle);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_length(int value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[LEN_W-1:0];
        @(posedge i_clk);
        sb.set_length(value);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        #30_000_000;
        $display("byte_nfa_active_set_stepper regression: fail");
        $finish;
    end

    initial begin
        int                  len;
        int                  span;
        int                  roll;
        int                  item_total;
        bit                  first_phase;
        bit [PROG_DEPTH-1:0] prefix;
        sb = new();
        item_total  = 0;
        first_phase = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty program: start, step and an ignored-mode item find nothing
        send_item(make_item(MODE_START, 0, OP_CHAR, 0, 0, -1, -1, 0));
        send_item(make_item(MODE_STEP, 0, OP_CHAR, 0, 0, -1, -1, 255));
        send_item(make_item(MODE_IGNORED, 63, OP_DEAD, 255, 255, 63, 63, 255));

        // Hand-built program touching every opcode
        wait_drained(SETTLE);
        write_length(8);
        send_item(make_item(MODE_LOAD, 0, OP_SPLIT, 0, 0, 1, 4, 0));
        send_item(make_item(MODE_LOAD, 1, OP_CHAR, 8'h61, 0, -1, 63, 0));
        send_item(make_item(MODE_LOAD, 2, OP_RANGE, 8'h30, 8'h39, 3, -1, 0));
        send_item(make_item(MODE_LOAD, 3, OP_JMP, 0, 0, 0, -1, 0));
        send_item(make_item(MODE_LOAD, 4, OP_SPLIT, 0, 0, 5, 7, 0));
        send_item(make_item(MODE_LOAD, 5, OP_NOT, 8'hFF, 0, -64, -1, 0));
        send_item(make_item(MODE_LOAD, 6, OP_MATCH, 0, 0, -1, -1, 0));
        send_item(make_item(MODE_LOAD, 7, OP_ANY, 0, 0, 8, -1, 0));
        send_item(make_item(MODE_LOAD, 63, OP_DEAD, 255, 255, 63, -64, 255));
        send_item(make_item(MODE_START, 0, OP_CHAR, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_STEP, 0, OP_CHAR, 0, 0, 0, 0, 8'h61));
        send_item(make_item(MODE_STEP, 0, OP_CHAR, 0, 0, 0, 0, 8'h35));
        send_item(make_item(MODE_STEP, 0, OP_CHAR, 0, 0, 0, 0, 8'h00));
        send_item(make_item(MODE_STEP, 0, OP_CHAR, 0, 0, 0, 0, 8'hFF));
        // Live status: the MATCH slot in the set turns into a CHAR
        send_item(make_item(MODE_LOAD, 6, OP_CHAR, 0, 0, 6, -1, 0));
        send_item(make_item(MODE_IGNORED, 0, OP_CHAR, 0, 0, 0, 0, 0));
        send_item(make_item(MODE_LOAD, 7, OP_DEAD, 0, 0, 8, -1, 0));
        send_item(make_item(MODE_START, 0, OP_CHAR, 0, 0, 0, 0, 0));
        // Shrunk length: set survives, new targets past the end are dropped
        wait_drained(SETTLE);
        write_length(2);
        send_item(make_item(MODE_STEP, 0, OP_CHAR, 0, 0, 0, 0, 8'h61));

        // Random programs, most of them started, run over random text
        while (item_total < RANDOM_ITEMS) begin
            wait_drained(SETTLE);
            roll = $urandom_range(0, 19);
            if (first_phase || roll == 0) len = $urandom_range(64, 127);
            else if (roll == 1)           len = 0;
            else if (roll < 4)            len = $urandom_range(17, 63);
            else                          len = $urandom_range(1, 16);
            if (first_phase) len = 127;
            first_phase = 1'b0;
            span   = (len < PROG_DEPTH) ? len : PROG_DEPTH;
            prefix = (span == PROG_DEPTH) ? '1 : ((64'd1 << span) - 64'd1);
            steady = ($urandom_range(0, 3) == 0);
            write_length(len);
            // every slot below the length must hold something before it is read
            if ((sb.loaded & prefix) != prefix || $urandom_range(0, 4) != 0) begin
                for (int s = 0; s < span; s++) begin
                    send_item(random_item(MODE_LOAD, s, span));
                    item_total++;
                end
            end
            if ($urandom_range(0, 5) != 0) begin
                send_item(random_item(MODE_START, $urandom_range(0, 63), 64));
                item_total++;
            end
            repeat ($urandom_range(4, 30)) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    send_item(random_item(MODE_IGNORED, $urandom_range(0, 63), 64));
                end else begin
                    if (roll == 1)      send_item(random_item(MODE_LOAD,
                                                              $urandom_range(0, 63), 64));
                    else if (roll == 2) send_item(random_item(MODE_START,
                                                              $urandom_range(0, 63), 64));
                    else                send_item(random_item(MODE_STEP,
                                                              $urandom_range(0, 63), 64));
                    item_total++;
                end
            end
        end

        wait_drained(DRAIN_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("byte_nfa_active_set_stepper regression: pass");
        end else begin
            $display("byte_nfa_active_set_stepper regression: fail");
        end
        $finish;
    end

endmodule

@@ byte_nfa_active_set_stepper.f @@
rtl/bnfa_pkg.sv
rtl/bnfa_ctrl.sv
rtl/bnfa_dp.sv
rtl/byte_nfa_active_set_stepper.sv
bench/tb_byte_nfa_active_set_stepper.sv
